// File: hdl/lsfb_pkg.sv
// Shared constants and beat types for the LED strip frame buffer.
package lsfb_pkg;

  localparam int unsigned MAX_PIXELS = 256;
  localparam int unsigned PIX_AW     = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W      = PIX_AW + 1;
  localparam int unsigned ACT_W      = 9;
  localparam int unsigned CFG_IW     = 2;
  localparam int unsigned CFG_DW     = 9;

  localparam logic [2:0] MODE_SET   = 3'd0;
  localparam logic [2:0] MODE_INC   = 3'd1;
  localparam logic [2:0] MODE_DEC   = 3'd2;
  localparam logic [2:0] MODE_SHIFT = 3'd3;
  localparam logic [2:0] MODE_FILL  = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_MAX_LEVEL = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_LEVEL = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ACTIVE    = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] pixel_index;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
    logic       shift_toward_end;
    logic       roll_around;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_t;

endpackage

// File: hdl/led_strip_frame_buffer.sv
// Top level of the LED strip frame buffer: pixel store, operation sequencer, result register.
//
//   channel | direction | handshake              | beat
//   in      | input     | in_valid_i / in_stall_o  | lsfb_pkg::in_t
//   out     | output    | out_valid_o / out_stall_i | lsfb_pkg::out_t
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Set, increase, decrease and read do one store read, then modify and write back.
// Out of range indexes and unused modes end without store access. Fill writes pixels
// one by one, shift moves one per write (plus one with roll): the store has one write port.
// Reset leaves the store dark at once through per-pixel valid bits; no clearing pass.
// A result waits in the output register; a new item is taken meanwhile, and the block
// holds its next result until that register is free.
module led_strip_frame_buffer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lsfb_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lsfb_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [lsfb_pkg::CFG_IW-1:0]      cfg_index_i,
  input  logic [lsfb_pkg::CFG_DW-1:0]      cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_ROLL  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int unsigned AW = lsfb_pkg::PIX_AW;

  logic [2:0] state_q, state_d;

  logic [7:0]                    max_q, min_q;
  logic [lsfb_pkg::ACT_W-1:0]    active_q;

  lsfb_pkg::in_t   op_q, op_d;
  lsfb_pkg::out_t  res_q, res_d;
  lsfb_pkg::out_t  out_q, out_d;
  logic            out_valid_q, out_valid_d;
  lsfb_pkg::pixel_t saved_q, saved_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            first_q, first_d;

  lsfb_pkg::pixel_t mem [lsfb_pkg::MAX_PIXELS];
  lsfb_pkg::pixel_t mem_rd_q;
  logic [lsfb_pkg::MAX_PIXELS-1:0] vld_q;
  logic            rvld_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  lsfb_pkg::pixel_t mem_wdata;
  lsfb_pkg::pixel_t pix;

  logic [lsfb_pkg::CNT_W-1:0] count;
  logic [AW-1:0]   last;
  logic            slot_free;
  logic            fin;
  lsfb_pkg::out_t  fin_res;
  logic            at_last;

  lsfb_pkg::pixel_t npix;
  logic [1:0]      pstat;
  logic [8:0]      sum_r, sum_g, sum_b;
  logic [7:0]      dec_r, dec_g, dec_b;

  always_comb begin
    if (active_q > lsfb_pkg::ACT_W'(lsfb_pkg::MAX_PIXELS)) begin
      count = lsfb_pkg::CNT_W'(lsfb_pkg::MAX_PIXELS);
    end else begin
      count = lsfb_pkg::CNT_W'(active_q);
    end
  end

  assign last      = AW'(count - lsfb_pkg::CNT_W'(1));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pix       = rvld_q ? mem_rd_q : '0;

  // pixel arithmetic
  always_comb begin
    sum_r = {1'b0, pix.red}   + {1'b0, op_q.red_value};
    sum_g = {1'b0, pix.green} + {1'b0, op_q.green_value};
    sum_b = {1'b0, pix.blue}  + {1'b0, op_q.blue_value};
    dec_r = pix.red;
    dec_g = pix.green;
    dec_b = pix.blue;
    if (pix.red > min_q) begin
      dec_r = (pix.red >= op_q.red_value) ? pix.red - op_q.red_value : 8'd0;
    end
    if (pix.green > min_q) begin
      dec_g = (pix.green >= op_q.green_value) ? pix.green - op_q.green_value : 8'd0;
    end
    if (pix.blue > min_q) begin
      dec_b = (pix.blue >= op_q.blue_value) ? pix.blue - op_q.blue_value : 8'd0;
    end
    npix  = pix;
    pstat = lsfb_pkg::ST_OK;
    unique case (op_q.mode)
      lsfb_pkg::MODE_SET: begin
        npix = '{red: op_q.red_value, green: op_q.green_value, blue: op_q.blue_value};
      end
      lsfb_pkg::MODE_INC: begin
        if (sum_r <= {1'b0, max_q} && sum_g <= {1'b0, max_q} && sum_b <= {1'b0, max_q}) begin
          npix = '{red: sum_r[7:0], green: sum_g[7:0], blue: sum_b[7:0]};
        end else begin
          pstat = lsfb_pkg::ST_LIMIT;
        end
      end
      lsfb_pkg::MODE_DEC: begin
        npix = '{red: dec_r, green: dec_g, blue: dec_b};
        if (dec_r <= min_q && dec_g <= min_q && dec_b <= min_q) begin
          pstat = lsfb_pkg::ST_LIMIT;
        end
      end
      default: begin
        npix = pix;
      end
    endcase
  end

  assign at_last = op_q.shift_toward_end ? (ptr_q == '0) : (ptr_q == last);

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    res_d     = res_q;
    saved_d   = saved_q;
    ptr_d     = ptr_q;
    first_d   = first_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = op_q.shift_toward_end ? pix : pix;
    mem_raddr = ptr_q;
    fin       = 1'b0;
    fin_res   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i;
          unique case (in_data_i.mode)
            lsfb_pkg::MODE_SET, lsfb_pkg::MODE_INC, lsfb_pkg::MODE_DEC,
            lsfb_pkg::MODE_READ: begin
              if ({1'b0, in_data_i.pixel_index} < count) begin
                mem_raddr = in_data_i.pixel_index;
                state_d   = S_PIX;
              end else begin
                fin            = 1'b1;
                fin_res.status = lsfb_pkg::ST_RANGE;
              end
            end
            lsfb_pkg::MODE_SHIFT: begin
              if (count >= lsfb_pkg::CNT_W'(2)) begin
                mem_raddr = in_data_i.shift_toward_end ? last : '0;
                ptr_d     = mem_raddr;
                first_d   = 1'b1;
                state_d   = S_SHIFT;
              end else begin
                fin = 1'b1;
              end
            end
            lsfb_pkg::MODE_FILL: begin
              if (count != '0) begin
                ptr_d   = '0;
                state_d = S_FILL;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_PIX: begin
        mem_we    = 1'b1;
        mem_waddr = op_q.pixel_index;
        mem_wdata = npix;
        fin       = 1'b1;
        fin_res   = '{status: pstat, red_out: npix.red, green_out: npix.green,
                      blue_out: npix.blue};
      end
      S_SHIFT: begin
        if (first_q) begin
          saved_d = pix;
          first_d = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = op_q.shift_toward_end ? ptr_q + AW'(1) : ptr_q - AW'(1);
          mem_wdata = pix;
        end
        if (at_last) begin
          if (op_q.roll_around) begin
            state_d = S_ROLL;
          end else begin
            fin = 1'b1;
          end
        end else begin
          mem_raddr = op_q.shift_toward_end ? ptr_q - AW'(1) : ptr_q + AW'(1);
          ptr_d     = mem_raddr;
        end
      end
      S_ROLL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = saved_q;
        fin       = 1'b1;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = '{red: op_q.red_value, green: op_q.green_value, blue: op_q.blue_value};
        if (ptr_q == last) begin
          fin = 1'b1;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_OUT: begin
        fin     = 1'b1;
        fin_res = res_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fin) begin
      if (slot_free) begin
        out_d       = fin_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      max_q       <= 8'd255;
      min_q       <= 8'd0;
      active_q    <= lsfb_pkg::ACT_W'(64);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
      rvld_q      <= vld_q[mem_raddr];
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lsfb_pkg::CFG_MAX_LEVEL: max_q    <= cfg_data_i[7:0];
          lsfb_pkg::CFG_MIN_LEVEL: min_q    <= cfg_data_i[7:0];
          lsfb_pkg::CFG_ACTIVE:    active_q <= cfg_data_i[lsfb_pkg::ACT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    res_q   <= res_d;
    out_q   <= out_d;
    saved_q <= saved_d;
    ptr_q   <= ptr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/lsfb_checker.sv
// Port-level checks for the LED strip frame buffer, bound to the top level.
module lsfb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  lsfb_pkg::out_t                   out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed under stall");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == lsfb_pkg::ST_OK ||
                    out_data_o.status == lsfb_pkg::ST_LIMIT ||
                    out_data_o.status == lsfb_pkg::ST_RANGE)
    else $error("undefined status code");

  a_range_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == lsfb_pkg::ST_RANGE |->
      out_data_o.red_out == 8'd0 && out_data_o.green_out == 8'd0 &&
      out_data_o.blue_out == 8'd0)
    else $error("out of range result carries a color");

  // an accepted item is either in progress or already shown
  a_item_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o || out_valid_o)
    else $error("accepted item vanished");

endmodule

bind led_strip_frame_buffer lsfb_checker u_lsfb_checker (.*);
